@@ rtl/core/gzhp_pkg.sv @@
package gzhp_pkg;

    localparam logic [7:0] MAGIC_A        = 8'h1f;
    localparam logic [7:0] MAGIC_B        = 8'h8b;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;
    localparam logic [7:0] FLG_RESERVED   = 8'hE0;
    localparam logic [4:0] FLG_HCRC       = 5'h02;
    localparam logic [4:0] FLG_EXTRA      = 5'h04;
    localparam logic [4:0] FLG_NAME       = 5'h08;
    localparam logic [4:0] FLG_COMMENT    = 5'h10;
    localparam logic [3:0] FIXED_LAST     = 4'd9;

    localparam logic [3:0] IDX_MAGIC_A = 4'd0;
    localparam logic [3:0] IDX_MAGIC_B = 4'd1;
    localparam logic [3:0] IDX_METHOD  = 4'd2;
    localparam logic [3:0] IDX_FLAGS   = 4'd3;
    localparam logic [3:0] IDX_TIME_LO = 4'd4;
    localparam logic [3:0] IDX_TIME_HI = 4'd7;
    localparam logic [4:0] HCRC_LEN    = 5'd2;

    typedef enum logic [3:0] {
        PH_FIXED   = 4'd0,
        PH_XLO     = 4'd1,
        PH_XHI     = 4'd2,
        PH_EXTRA   = 4'd3,
        PH_NAME    = 4'd4,
        PH_COMMENT = 4'd5,
        PH_HCRC    = 4'd6,
        PH_PAYLOAD = 4'd7
    } t_phase;

    typedef enum logic [2:0] {
        ST_HEADER = 3'd0,
        ST_DONE   = 3'd1,
        ST_MAGIC  = 3'd2,
        ST_METHOD = 3'd3,
        ST_FLAGS  = 3'd4,
        ST_TRUNC  = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       first_byte;
        logic       final_byte;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [31:0] mod_time;
        logic        payload_valid;
        logic [7:0]  payload_byte;
    } t_out;

    // First optional section after 'from' that the flags enable, else the payload phase.
    function automatic t_phase next_phase(input t_phase from, input logic [4:0] flags);
        t_phase result;
        if (from < PH_XLO && (flags & FLG_EXTRA) != 5'd0) begin
            result = PH_XLO;
        end else if (from < PH_NAME && (flags & FLG_NAME) != 5'd0) begin
            result = PH_NAME;
        end else if (from < PH_COMMENT && (flags & FLG_COMMENT) != 5'd0) begin
            result = PH_COMMENT;
        end else if (from < PH_HCRC && (flags & FLG_HCRC) != 5'd0) begin
            result = PH_HCRC;
        end else begin
            result = PH_PAYLOAD;
        end
        return result;
    endfunction

endpackage

@@ rtl/core/gzip_header_parser.sv @@
// A byte's result is registered (one result register) unless the output is stalled.
// Throughput: one byte per cycle while the skid register is empty; the header state updates in one pass per byte.
// A skid register takes one more result while the output is stalled.
// Reset (i_rst_n low at a clock edge, synchronous) returns the parser to the fixed header,
// clears the fault and empties the output and skid registers.
module gzip_header_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gzhp_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output gzhp_pkg::t_out o_out_data
);

    gzhp_pkg::t_phase  r_phase, n_phase;
    logic [3:0]        r_index, n_index;
    logic [4:0]        r_flags, n_flags;
    logic [7:0]        r_extra_low, n_extra_low;
    logic [15:0]       r_extra_rem, n_extra_rem;
    logic [31:0]       r_time, n_time;
    gzhp_pkg::t_status r_fault, n_fault;

    logic              r_out_valid;
    logic              r_skid_valid;
    gzhp_pkg::t_out    r_out;
    gzhp_pkg::t_out    r_skid;
    gzhp_pkg::t_out    n_result;

    logic              in_fire;
    logic              out_fire;
    logic [7:0]        b;
    logic [4:0]        crc_count;
    logic [15:0]       extra_dec;
    logic              pay;

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign b           = i_in_data.stream_byte;

    always_comb begin
        // start from reset values when a new stream begins
        if (i_in_data.first_byte) begin
            n_phase     = gzhp_pkg::PH_FIXED;
            n_index     = 4'd0;
            n_flags     = 5'd0;
            n_extra_low = 8'd0;
            n_extra_rem = 16'd0;
            n_time      = 32'd0;
            n_fault     = gzhp_pkg::ST_HEADER;
        end else begin
            n_phase     = r_phase;
            n_index     = r_index;
            n_flags     = r_flags;
            n_extra_low = r_extra_low;
            n_extra_rem = r_extra_rem;
            n_time      = r_time;
            n_fault     = r_fault;
        end
        pay       = 1'b0;
        crc_count = {1'b0, n_index} + 5'd1;
        extra_dec = (n_extra_rem != 16'd0) ? n_extra_rem - 16'd1 : n_extra_rem;

        if (n_fault == gzhp_pkg::ST_HEADER) begin
            unique case (n_phase) inside
                gzhp_pkg::PH_FIXED: begin
                    if (n_index == gzhp_pkg::IDX_MAGIC_A && b != gzhp_pkg::MAGIC_A) begin
                        n_fault = gzhp_pkg::ST_MAGIC;
                    end else if (n_index == gzhp_pkg::IDX_MAGIC_B
                                 && b != gzhp_pkg::MAGIC_B) begin
                        n_fault = gzhp_pkg::ST_MAGIC;
                    end else if (n_index == gzhp_pkg::IDX_METHOD
                                 && b != gzhp_pkg::METHOD_DEFLATE) begin
                        n_fault = gzhp_pkg::ST_METHOD;
                    end else if (n_index == gzhp_pkg::IDX_FLAGS) begin
                        if ((b & gzhp_pkg::FLG_RESERVED) != 8'd0) begin
                            n_fault = gzhp_pkg::ST_FLAGS;
                        end else begin
                            n_flags = b[4:0];
                        end
                    end else if (n_index >= gzhp_pkg::IDX_TIME_LO
                                 && n_index <= gzhp_pkg::IDX_TIME_HI) begin
                        unique case (n_index[1:0])
                            2'd0:    n_time[7:0]   = b;
                            2'd1:    n_time[15:8]  = b;
                            2'd2:    n_time[23:16] = b;
                            default: n_time[31:24] = b;
                        endcase
                    end
                    if (n_index >= gzhp_pkg::FIXED_LAST) begin
                        n_index = 4'd0;
                        n_phase = gzhp_pkg::next_phase(gzhp_pkg::PH_FIXED, n_flags);
                    end else begin
                        n_index = crc_count[3:0];
                    end
                end
                gzhp_pkg::PH_XLO: begin
                    n_extra_low = b;
                    n_phase     = gzhp_pkg::PH_XHI;
                end
                gzhp_pkg::PH_XHI: begin
                    n_extra_rem = {b, n_extra_low};
                    n_phase     = ({b, n_extra_low} != 16'd0) ? gzhp_pkg::PH_EXTRA
                                : gzhp_pkg::next_phase(gzhp_pkg::PH_EXTRA, n_flags);
                end
                gzhp_pkg::PH_EXTRA: begin
                    n_extra_rem = extra_dec;
                    if (extra_dec == 16'd0) begin
                        n_phase = gzhp_pkg::next_phase(gzhp_pkg::PH_EXTRA, n_flags);
                    end
                end
                gzhp_pkg::PH_NAME, gzhp_pkg::PH_COMMENT: begin
                    if (b == 8'd0) begin
                        n_phase = gzhp_pkg::next_phase(n_phase, n_flags);
                    end
                end
                gzhp_pkg::PH_HCRC: begin
                    if (crc_count >= gzhp_pkg::HCRC_LEN) begin
                        n_index = 4'd0;
                        n_phase = gzhp_pkg::next_phase(gzhp_pkg::PH_HCRC, n_flags);
                    end else begin
                        n_index = crc_count[3:0];
                    end
                end
                default: begin
                    // payload, and any unused phase code
                    pay = 1'b1;
                end
            endcase
            if (n_fault == gzhp_pkg::ST_HEADER && n_phase < gzhp_pkg::PH_PAYLOAD
                && i_in_data.final_byte) begin
                n_fault = gzhp_pkg::ST_TRUNC;
            end
        end

        n_result.mod_time = n_time;
        if (n_fault != gzhp_pkg::ST_HEADER) begin
            n_result.status        = n_fault;
            n_result.payload_valid = 1'b0;
            n_result.payload_byte  = 8'd0;
        end else begin
            n_result.status        = (n_phase >= gzhp_pkg::PH_PAYLOAD) ? gzhp_pkg::ST_DONE
                                   : gzhp_pkg::ST_HEADER;
            n_result.payload_valid = pay;
            n_result.payload_byte  = pay ? b : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= gzhp_pkg::PH_FIXED;
            r_index     <= 4'd0;
            r_flags     <= 5'd0;
            r_extra_low <= 8'd0;
            r_extra_rem <= 16'd0;
            r_time      <= 32'd0;
            r_fault     <= gzhp_pkg::ST_HEADER;
        end else if (in_fire) begin
            r_phase     <= n_phase;
            r_index     <= n_index;
            r_flags     <= n_flags;
            r_extra_low <= n_extra_low;
            r_extra_rem <= n_extra_rem;
            r_time      <= n_time;
            r_fault     <= n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            // park the result in the skid register while the output is stalled
            if (r_out_valid && !out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_fire) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (r_out_valid && !out_fire) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end else if (out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule
